// ===== rtl/ccc_pkg.sv =====
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types, constants and the month-length table of the calendar counter.
// ----------------------------------------------------------------------------
package ccc_pkg;

    // working width of the small calendar fields during normalisation
    localparam int unsigned CW = 9;
    localparam int unsigned YW = 16;

    typedef logic [CW-1:0] t_cnt;
    typedef logic [YW-1:0] t_year;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_SET      = 2'd1,
        CMD_ADD_TIME = 2'd2,
        CMD_ADD_DATE = 2'd3
    } t_cmd;

    // carry limits (value above LIM gives up MOD to the next field)
    localparam t_cnt SEC_LIM  = t_cnt'(59);
    localparam t_cnt SEC_MOD  = t_cnt'(60);
    localparam t_cnt HOUR_LIM = t_cnt'(23);
    localparam t_cnt HOUR_MOD = t_cnt'(24);
    localparam t_cnt MON_LIM  = t_cnt'(12);
    localparam t_cnt MON_MOD  = t_cnt'(12);
    localparam t_cnt MON_FEB  = t_cnt'(2);

    // month index runs 0..11, December at 0
    localparam logic [3:0] IDX_LAST = 4'd11;

    // request to and answer from the shared compare/subtract unit
    typedef struct packed {
        t_cnt  x;
        t_cnt  lim;
        t_cnt  sub;
        t_year tgt;
    } t_alu_req;

    typedef struct packed {
        logic  take;
        t_cnt  x_next;
        t_year tgt_next;
    } t_alu_rsp;

    function automatic logic [4:0] month_len(input logic [3:0] idx);
        logic [4:0] len;
        case (idx)
            4'd0:    len = 5'd31;
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/ccc_alu.sv =====
// ----------------------------------------------------------------------------
// ccc_alu
// Shared carry step: compare a field with its limit, subtract, bump target.
// ----------------------------------------------------------------------------
module ccc_alu
    import ccc_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    assign o_rsp.take     = (i_req.x > i_req.lim);
    assign o_rsp.x_next   = i_req.x - i_req.sub;
    assign o_rsp.tgt_next = i_req.tgt + t_year'(1);   // year wraps mod 2^16

endmodule

// ===== rtl/calendar_clock_counter.sv =====
// ----------------------------------------------------------------------------
// calendar_clock_counter
// Year/month/day/hour/minute/second counter with tick, set and add commands.
// ----------------------------------------------------------------------------
// Input channel s_axis: one item per command. tuser carries the command
// (tick, set, add time, add date), tdata the amounts. The item is taken
// only while the sequencer is idle.
// Output channel m_axis: one item per command with the whole calendar
// after normalisation, held in an output register until taken.
// Sequence: a load step, then the normalisation stages in order (seconds,
// minutes, hours, month carry, day reduction, month carry), each doing one
// carry step at a time through the single compare/subtract unit, then a
// load of the output register. Add date skips the time stages; a set
// normalises twice.
// Items are handled one at a time; the next item is taken as soon as the
// result has moved to the output register, even if it is not yet taken.
// Stall: if the receiver holds m_axis_tready low, the finished item waits
// in the done state until the output register is free.
// Reset (i_rst_n low, synchronous): calendar cleared to zero, no item
// pending on either side.
// ----------------------------------------------------------------------------
module calendar_clock_counter
    import ccc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // year_amount[15:0], month_amount[23:16], day_amount[31:24],
    // hour_amount[39:32], minute_amount[47:40], second_amount[55:48]
    input  logic [55:0] s_axis_tdata,
    // command[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // year_now[15:0], month_now[19:16], day_now[24:20], hour_now[29:25],
    // minute_now[35:30], second_now[41:36], zero fill above
    output logic [47:0] m_axis_tdata
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SEC  = 9'b000000010,
        S_MIN  = 9'b000000100,
        S_HOUR = 9'b000001000,
        S_MON1 = 9'b000010000,
        S_DAY  = 9'b000100000,
        S_MON2 = 9'b001000000,
        S_DATE = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // working calendar; normalised between items
    t_year r_yr, n_yr;
    t_cnt  r_mo, n_mo;
    t_cnt  r_dy, n_dy;
    t_cnt  r_hr, n_hr;
    t_cnt  r_mi, n_mi;
    t_cnt  r_se, n_se;

    // date amounts kept for the date add of add date and of a set's second pass
    t_year      r_ya, n_ya;
    logic [7:0] r_moa, n_moa;
    logic [7:0] r_da, n_da;
    logic       r_pend, n_pend;

    // day reduction: month index (mo mod 12), leap decision, first month
    logic [3:0] r_idx, n_idx;
    logic       r_leap, n_leap;
    logic       r_first, n_first;

    logic        r_m_valid, n_m_valid;
    logic [47:0] r_m_data, n_m_data;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;
    t_cnt     day_lim;
    t_cmd     cmd_in;
    logic     in_take;

    ccc_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign cmd_in        = t_cmd'(s_axis_tuser);
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    assign day_lim = t_cnt'(month_len(r_idx)) + t_cnt'(r_leap && r_first);

    // operand select for the shared unit
    always_comb begin
        alu_req = '{x: r_se, lim: SEC_LIM, sub: SEC_MOD, tgt: t_year'(r_mi)};
        unique case (r_state)
            S_MIN:  alu_req = '{x: r_mi, lim: SEC_LIM, sub: SEC_MOD, tgt: t_year'(r_hr)};
            S_HOUR: alu_req = '{x: r_hr, lim: HOUR_LIM, sub: HOUR_MOD, tgt: t_year'(r_dy)};
            S_MON1,
            S_MON2: alu_req = '{x: r_mo, lim: MON_LIM, sub: MON_MOD, tgt: r_yr};
            S_DAY:  alu_req = '{x: r_dy, lim: day_lim, sub: day_lim, tgt: t_year'(r_mo)};
            default: ;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_yr      = r_yr;
        n_mo      = r_mo;
        n_dy      = r_dy;
        n_hr      = r_hr;
        n_mi      = r_mi;
        n_se      = r_se;
        n_ya      = r_ya;
        n_moa     = r_moa;
        n_da      = r_da;
        n_pend    = r_pend;
        n_idx     = r_idx;
        n_leap    = r_leap;
        n_first   = r_first;
        n_m_data  = r_m_data;
        n_m_valid = r_m_valid && !m_axis_tready;

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_ya   = s_axis_tdata[15:0];
                    n_moa  = s_axis_tdata[23:16];
                    n_da   = s_axis_tdata[31:24];
                    n_pend = 1'b0;
                    n_state = S_SEC;
                    unique case (cmd_in)
                        CMD_TICK: begin
                            n_se = r_se + t_cnt'(1);
                        end
                        CMD_SET: begin
                            n_yr   = '0;
                            n_mo   = '0;
                            n_dy   = '0;
                            n_hr   = t_cnt'(s_axis_tdata[39:32]);
                            n_mi   = t_cnt'(s_axis_tdata[47:40]);
                            n_se   = t_cnt'(s_axis_tdata[55:48]);
                            n_pend = 1'b1;
                        end
                        CMD_ADD_TIME: begin
                            n_hr = r_hr + t_cnt'(s_axis_tdata[39:32]);
                            n_mi = r_mi + t_cnt'(s_axis_tdata[47:40]);
                            n_se = r_se + t_cnt'(s_axis_tdata[55:48]);
                        end
                        CMD_ADD_DATE: begin
                            // time is already normalised: straight to the date add
                            n_state = S_DATE;
                        end
                    endcase
                end
            end
            S_SEC: begin
                if (alu_rsp.take) begin
                    n_se = alu_rsp.x_next;
                    n_mi = alu_rsp.tgt_next[CW-1:0];
                end else begin
                    n_state = S_MIN;
                end
            end
            S_MIN: begin
                if (alu_rsp.take) begin
                    n_mi = alu_rsp.x_next;
                    n_hr = alu_rsp.tgt_next[CW-1:0];
                end else begin
                    n_state = S_HOUR;
                end
            end
            S_HOUR: begin
                if (alu_rsp.take) begin
                    n_hr = alu_rsp.x_next;
                    n_dy = alu_rsp.tgt_next[CW-1:0];
                end else begin
                    n_state = S_MON1;
                end
            end
            S_MON1: begin
                if (alu_rsp.take) begin
                    n_mo = alu_rsp.x_next;
                    n_yr = alu_rsp.tgt_next;
                end else begin
                    // month is 0..12 here: December maps to index 0
                    n_idx   = (r_mo == MON_LIM) ? 4'd0 : r_mo[3:0];
                    n_leap  = (r_mo == MON_FEB) && (r_yr[1:0] == 2'b00);
                    n_first = 1'b1;
                    n_state = S_DAY;
                end
            end
            S_DAY: begin
                if (alu_rsp.take) begin
                    n_dy    = alu_rsp.x_next;
                    n_mo    = alu_rsp.tgt_next[CW-1:0];
                    n_idx   = (r_idx == IDX_LAST) ? 4'd0 : r_idx + 4'd1;
                    n_first = 1'b0;
                end else begin
                    n_state = S_MON2;
                end
            end
            S_MON2: begin
                if (alu_rsp.take) begin
                    n_mo = alu_rsp.x_next;
                    n_yr = alu_rsp.tgt_next;
                end else begin
                    n_state = r_pend ? S_DATE : S_DONE;
                end
            end
            S_DATE: begin
                n_yr    = r_yr + r_ya;
                n_mo    = r_mo + t_cnt'(r_moa);
                n_dy    = r_dy + t_cnt'(r_da);
                n_pend  = 1'b0;
                n_state = S_MON1;
            end
            S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_data  = {6'b0, r_se[5:0], r_mi[5:0], r_hr[4:0], r_dy[4:0],
                                 r_mo[3:0], r_yr};
                    n_m_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_yr      <= '0;
            r_mo      <= '0;
            r_dy      <= '0;
            r_hr      <= '0;
            r_mi      <= '0;
            r_se      <= '0;
            r_pend    <= 1'b0;
            r_idx     <= '0;
            r_leap    <= 1'b0;
            r_first   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_yr      <= n_yr;
            r_mo      <= n_mo;
            r_dy      <= n_dy;
            r_hr      <= n_hr;
            r_mi      <= n_mi;
            r_se      <= n_se;
            r_pend    <= n_pend;
            r_idx     <= n_idx;
            r_leap    <= n_leap;
            r_first   <= n_first;
            r_m_valid <= n_m_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ya     <= n_ya;
        r_moa    <= n_moa;
        r_da     <= n_da;
        r_m_data <= n_m_data;
    end

endmodule
